[hdl/salcp_pkg.sv]
// Shared types, widths and command codes for the suffix array LCP core.
// Used by the controller, the datapath, the top level and the checker.
package salcp_pkg;

    // Field widths fixed by the word format.
    localparam int IDX_W    = 10;
    localparam int LEN_W    = IDX_W + 1;
    localparam int SUM_W    = LEN_W + 1;
    localparam int SYM_IN_W = 16;
    localparam int LCP_W    = 10;
    localparam int CNT_W    = 20;
    localparam int ACC_W    = 21;
    localparam int PROD_W   = 2 * LEN_W;

    localparam logic [LCP_W-1:0] LCP_MAX = '1;

    // Defaults for the top-level parameters.
    localparam int MAX_LEN_DEF      = 1024;
    localparam int SYMBOL_WIDTH_DEF = 16;

    // Command field of an input word.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Datapath operations issued by the controller.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
    localparam logic [OP_W-1:0] OP_INIT     = 4'd2;
    localparam logic [OP_W-1:0] OP_RANK_RD  = 4'd3;
    localparam logic [OP_W-1:0] OP_RANK_WR  = 4'd4;
    localparam logic [OP_W-1:0] OP_WALK_RK  = 4'd5;
    localparam logic [OP_W-1:0] OP_WALK_SUF = 4'd6;
    localparam logic [OP_W-1:0] OP_CMP_RD   = 4'd7;
    localparam logic [OP_W-1:0] OP_CMP_EQ   = 4'd8;
    localparam logic [OP_W-1:0] OP_STORE    = 4'd9;
    localparam logic [OP_W-1:0] OP_TOTAL    = 4'd10;
    localparam logic [OP_W-1:0] OP_FINISH   = 4'd11;

    typedef struct packed {
        logic                cmd;
        logic [IDX_W-1:0]    index;
        logic [SYM_IN_W-1:0] symbol;
        logic [IDX_W-1:0]    suffix_pos;
        logic                last;
    } in_t;

    typedef struct packed {
        logic [LCP_W-1:0] lcp_value;
        logic [CNT_W-1:0] distinct_count;
        logic             out_of_range;
    } out_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
    } ctl_cmd_t;

    typedef struct packed {
        logic final_load;
        logic last_u;
        logic rk_tail;
        logic cmp_ok;
        logic sym_eq;
    } ctl_status_t;

endpackage

[hdl/salcp_ctrl.sv]
// Sequencing state machine for the LCP core: word acceptance and the Kasai walk.
// Depends on salcp_pkg for the operation codes and the command/status structs.
module salcp_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  salcp_pkg::ctl_status_t status,
    output logic                  busy,
    output salcp_pkg::ctl_cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_INIT     = 4'd1;
    localparam logic [3:0] ST_RANK_RD  = 4'd2;
    localparam logic [3:0] ST_RANK_WR  = 4'd3;
    localparam logic [3:0] ST_WALK_RK  = 4'd4;
    localparam logic [3:0] ST_WALK_SUF = 4'd5;
    localparam logic [3:0] ST_CMP_RD   = 4'd6;
    localparam logic [3:0] ST_CMP_EQ   = 4'd7;
    localparam logic [3:0] ST_STORE    = 4'd8;
    localparam logic [3:0] ST_TOTAL    = 4'd9;
    localparam logic [3:0] ST_FINISH   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = salcp_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op = salcp_pkg::OP_ACCEPT;
                    if (status.final_load)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                cmd.op = salcp_pkg::OP_INIT;
                if (status.last_u)
                begin
                    state_next = ST_RANK_RD;
                end
            end
            ST_RANK_RD:
            begin
                cmd.op     = salcp_pkg::OP_RANK_RD;
                state_next = ST_RANK_WR;
            end
            ST_RANK_WR:
            begin
                cmd.op     = salcp_pkg::OP_RANK_WR;
                state_next = status.last_u ? ST_WALK_RK : ST_RANK_RD;
            end
            ST_WALK_RK:
            begin
                cmd.op     = salcp_pkg::OP_WALK_RK;
                state_next = ST_WALK_SUF;
            end
            ST_WALK_SUF:
            begin
                // A suffix ranked last has no successor: its matched length restarts at zero.
                cmd.op = salcp_pkg::OP_WALK_SUF;
                if (status.rk_tail)
                begin
                    state_next = status.last_u ? ST_TOTAL : ST_WALK_RK;
                end
                else
                begin
                    state_next = ST_CMP_RD;
                end
            end
            ST_CMP_RD:
            begin
                cmd.op     = salcp_pkg::OP_CMP_RD;
                state_next = status.cmp_ok ? ST_CMP_EQ : ST_STORE;
            end
            ST_CMP_EQ:
            begin
                cmd.op     = salcp_pkg::OP_CMP_EQ;
                state_next = status.sym_eq ? ST_CMP_RD : ST_STORE;
            end
            ST_STORE:
            begin
                cmd.op     = salcp_pkg::OP_STORE;
                state_next = status.last_u ? ST_TOTAL : ST_WALK_RK;
            end
            ST_TOTAL:
            begin
                cmd.op     = salcp_pkg::OP_TOTAL;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.op     = salcp_pkg::OP_FINISH;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

[hdl/salcp_dp.sv]
// Datapath of the LCP core: symbol, suffix, rank and LCP memories, walk counters
// and the distinct-substring count. Depends on salcp_pkg; driven by salcp_ctrl.
module salcp_dp
#(
    parameter int MAX_LEN      = salcp_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_WIDTH = salcp_pkg::SYMBOL_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  salcp_pkg::in_t          item,
    input  salcp_pkg::ctl_cmd_t     cmd,
    output salcp_pkg::ctl_status_t  status,
    output logic                   done,
    output salcp_pkg::out_t         result
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    logic [SYMBOL_WIDTH-1:0]     sym_mem [MAX_LEN];
    logic [salcp_pkg::IDX_W-1:0] suf_mem [MAX_LEN];
    logic [salcp_pkg::IDX_W-1:0] rank_mem [MAX_LEN];
    logic [salcp_pkg::LCP_W-1:0] lcp_mem [MAX_LEN];

    logic [SYMBOL_WIDTH-1:0]     sym_a_q;
    logic [SYMBOL_WIDTH-1:0]     sym_b_q;
    logic [salcp_pkg::IDX_W-1:0] suf_q;
    logic [salcp_pkg::IDX_W-1:0] rank_q;
    logic [salcp_pkg::LCP_W-1:0] lcp_q;

    logic [salcp_pkg::LEN_W-1:0] len_reg;
    logic [salcp_pkg::CNT_W-1:0] distinct_reg;
    logic [salcp_pkg::IDX_W-1:0] u_reg;
    logic [salcp_pkg::IDX_W-1:0] rk_reg;
    logic [salcp_pkg::LEN_W-1:0] h_reg;
    logic [salcp_pkg::ACC_W-1:0] acc_reg;
    logic [salcp_pkg::ACC_W-1:0] total_reg;
    logic                        oor_reg;
    logic                        done_reg;

    logic                         is_load;
    logic                         is_read;
    logic                         in_range;
    logic [salcp_pkg::LEN_W-1:0]  index_plus1;
    logic [salcp_pkg::LEN_W-1:0]  rank_plus1;
    logic [salcp_pkg::SUM_W-1:0]  u_plus_h;
    logic [salcp_pkg::SUM_W-1:0]  v_plus_h;
    logic [salcp_pkg::IDX_W-1:0]  u_adv;
    logic [salcp_pkg::LCP_W-1:0]  lcp_sat;
    logic [salcp_pkg::PROD_W-1:0] prod;

    logic                         suf_re;
    logic [AW-1:0]                suf_raddr;
    logic                         rank_we;
    logic [AW-1:0]                rank_waddr;
    logic [salcp_pkg::IDX_W-1:0]  rank_wdata;
    logic                         lcp_we;
    logic [AW-1:0]                lcp_waddr;
    logic [salcp_pkg::LCP_W-1:0]  lcp_wdata;

    assign is_load     = (cmd.op == salcp_pkg::OP_ACCEPT) && (item.cmd == salcp_pkg::CMD_LOAD)
                         && in_range;
    assign is_read     = (cmd.op == salcp_pkg::OP_ACCEPT) && (item.cmd == salcp_pkg::CMD_READ);
    assign in_range    = (32'(item.index) < MAX_LEN);
    assign index_plus1 = salcp_pkg::LEN_W'(item.index) + salcp_pkg::LEN_W'(1);
    assign rank_plus1  = salcp_pkg::LEN_W'(rank_q) + salcp_pkg::LEN_W'(1);
    assign u_plus_h    = salcp_pkg::SUM_W'(u_reg) + salcp_pkg::SUM_W'(h_reg);
    assign v_plus_h    = salcp_pkg::SUM_W'(suf_q) + salcp_pkg::SUM_W'(h_reg);
    assign lcp_sat     = (h_reg > salcp_pkg::LEN_W'(salcp_pkg::LCP_MAX))
                         ? salcp_pkg::LCP_MAX : h_reg[salcp_pkg::LCP_W-1:0];
    assign prod        = salcp_pkg::PROD_W'(len_reg)
                         * salcp_pkg::PROD_W'(len_reg + salcp_pkg::LEN_W'(1));

    assign status.final_load = (item.cmd == salcp_pkg::CMD_LOAD) && item.last && in_range;
    assign status.last_u     = (salcp_pkg::LEN_W'(u_reg) == (len_reg - salcp_pkg::LEN_W'(1)));
    assign status.rk_tail    = (rank_plus1 >= len_reg);
    assign status.cmp_ok     = (u_plus_h < salcp_pkg::SUM_W'(len_reg))
                               && (v_plus_h < salcp_pkg::SUM_W'(len_reg));
    assign status.sym_eq     = (sym_a_q == sym_b_q);

    assign u_adv = status.last_u ? '0 : u_reg + salcp_pkg::IDX_W'(1);

    // Memory port selection.
    always_comb
    begin
        suf_re     = (cmd.op == salcp_pkg::OP_RANK_RD)
                     || ((cmd.op == salcp_pkg::OP_WALK_SUF) && !status.rk_tail);
        suf_raddr  = (cmd.op == salcp_pkg::OP_WALK_SUF) ? AW'(rank_plus1) : AW'(u_reg);
        rank_we    = (cmd.op == salcp_pkg::OP_INIT)
                     || ((cmd.op == salcp_pkg::OP_RANK_WR)
                         && (salcp_pkg::LEN_W'(suf_q) < len_reg));
        rank_waddr = (cmd.op == salcp_pkg::OP_INIT) ? AW'(u_reg) : AW'(suf_q);
        rank_wdata = (cmd.op == salcp_pkg::OP_INIT)
                     ? salcp_pkg::IDX_W'(len_reg - salcp_pkg::LEN_W'(1)) : u_reg;
        lcp_we     = (cmd.op == salcp_pkg::OP_INIT) || (cmd.op == salcp_pkg::OP_STORE);
        lcp_waddr  = (cmd.op == salcp_pkg::OP_INIT) ? AW'(u_reg) : AW'(rk_reg);
        lcp_wdata  = (cmd.op == salcp_pkg::OP_INIT) ? '0 : lcp_sat;
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            sym_mem[AW'(item.index)] <= SYMBOL_WIDTH'(item.symbol);
        end
        if ((cmd.op == salcp_pkg::OP_CMP_RD) && status.cmp_ok)
        begin
            sym_a_q <= sym_mem[AW'(u_plus_h)];
            sym_b_q <= sym_mem[AW'(v_plus_h)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            suf_mem[AW'(item.index)] <= item.suffix_pos;
        end
        if (suf_re)
        begin
            suf_q <= suf_mem[suf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rank_we)
        begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        if (cmd.op == salcp_pkg::OP_WALK_RK)
        begin
            rank_q <= rank_mem[AW'(u_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (lcp_we)
        begin
            lcp_mem[lcp_waddr] <= lcp_wdata;
        end
        if (is_read)
        begin
            lcp_q <= lcp_mem[AW'(item.index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            distinct_reg <= '0;
            u_reg        <= '0;
            rk_reg       <= '0;
            h_reg        <= '0;
            acc_reg      <= '0;
            total_reg    <= '0;
            oor_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (cmd.op)
                salcp_pkg::OP_ACCEPT:
                begin
                    if (item.cmd == salcp_pkg::CMD_READ)
                    begin
                        done_reg <= 1'b1;
                        oor_reg  <= !(index_plus1 < len_reg);
                    end
                    else if (status.final_load)
                    begin
                        len_reg <= index_plus1;
                        u_reg   <= '0;
                        h_reg   <= '0;
                        acc_reg <= '0;
                    end
                end
                salcp_pkg::OP_INIT, salcp_pkg::OP_RANK_WR:
                begin
                    u_reg <= u_adv;
                end
                salcp_pkg::OP_WALK_SUF:
                begin
                    rk_reg <= rank_q;
                    if (status.rk_tail)
                    begin
                        h_reg <= '0;
                        u_reg <= u_adv;
                    end
                end
                salcp_pkg::OP_CMP_EQ:
                begin
                    if (status.sym_eq)
                    begin
                        h_reg <= h_reg + salcp_pkg::LEN_W'(1);
                    end
                end
                salcp_pkg::OP_STORE:
                begin
                    // Each rank below the last is stored at most once, so the sum can be kept here.
                    acc_reg <= acc_reg + salcp_pkg::ACC_W'(lcp_sat);
                    h_reg   <= (h_reg != '0) ? h_reg - salcp_pkg::LEN_W'(1) : '0;
                    u_reg   <= u_adv;
                end
                salcp_pkg::OP_TOTAL:
                begin
                    total_reg <= salcp_pkg::ACC_W'(prod >> 1);
                end
                salcp_pkg::OP_FINISH:
                begin
                    distinct_reg <= (total_reg > acc_reg)
                                    ? salcp_pkg::CNT_W'(total_reg - acc_reg) : '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign done                  = done_reg;
    assign result.lcp_value      = oor_reg ? '0 : lcp_q;
    assign result.distinct_count = distinct_reg;
    assign result.out_of_range   = oor_reg;

endmodule

[hdl/suffix_array_lcp_kasai_core.sv]
// Top level of the suffix array LCP core (Kasai's method).
// Depends on salcp_pkg, salcp_ctrl and salcp_dp.
//
// A word is taken at a clock edge where start is high and busy is low. A load word
// with an index below MAX_LEN writes one symbol and one suffix array entry. The result
// of a read word is on result for exactly the next cycle, marked by done;
// the receiver cannot hold it, so it must take it then. The in-range load marked last
// starts the LCP run and busy stays high until it ends. The run goes through the
// memories in order: it seeds the rank and LCP tables, builds the ranks, then per
// suffix fetches its rank and neighbor. A suffix with a neighbor then reads and
// compares one symbol pair per matched symbol, ends the match with a failed bound
// check or symbol compare, and stores its LCP; the run ends with the final count.
// The matched length drops by at most one per stored suffix and restarts at zero
// at a suffix ranked last. Results are meaningful for string lengths up to MAX_LEN.
module suffix_array_lcp_kasai_core
#(
    parameter int MAX_LEN      = salcp_pkg::MAX_LEN_DEF,
    parameter int SYMBOL_WIDTH = salcp_pkg::SYMBOL_WIDTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  salcp_pkg::in_t  item,
    output logic           done,
    output salcp_pkg::out_t result
);

    salcp_pkg::ctl_cmd_t    ctl_cmd;
    salcp_pkg::ctl_status_t ctl_status;

    salcp_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (ctl_status),
        .busy   (busy),
        .cmd    (ctl_cmd)
    );

    salcp_dp
    #(
        .MAX_LEN      (MAX_LEN),
        .SYMBOL_WIDTH (SYMBOL_WIDTH)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (ctl_cmd),
        .status (ctl_status),
        .done   (done),
        .result (result)
    );

endmodule

[hdl/salcp_checker.sv]
// Port-level checks for the suffix array LCP core, bound to the top level.
// Depends on salcp_pkg for the word types.
module salcp_checker
#(
    parameter int MAX_LEN = salcp_pkg::MAX_LEN_DEF
)
(
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input salcp_pkg::in_t  item,
    input logic           done,
    input salcp_pkg::out_t result
);

    logic read_acc;
    logic run_acc;

    assign read_acc = start && !busy && (item.cmd == salcp_pkg::CMD_READ);
    assign run_acc  = start && !busy && (item.cmd == salcp_pkg::CMD_LOAD) && item.last
                      && (32'(item.index) < MAX_LEN);

    a_read_answers: assert property (@(posedge clk) disable iff (!rst_n)
        read_acc |=> done)
        else $error("read word not answered in the next cycle");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(read_acc))
        else $error("result shown without a read word");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |-> (result.lcp_value == '0))
        else $error("out-of-range read returned a nonzero LCP");

    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        run_acc |=> busy)
        else $error("final load did not start a run");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && $past(!busy) |-> $stable(result.distinct_count))
        else $error("distinct count changed outside a run");

endmodule

bind suffix_array_lcp_kasai_core salcp_checker #(.MAX_LEN(MAX_LEN)) u_checker (.*);

[bench/tb.sv]
// Self-checking bench for suffix_array_lcp_kasai_core: loads strings with their suffix arrays,
// predicts the LCP table and distinct-substring count, and checks every read word.
// Depends on salcp_pkg and the core RTL only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import salcp_pkg::*;

    localparam int DEPTH = MAX_LEN_DEF;
    localparam longint COUNT_TOP = (longint'(1) << CNT_W) - 1;

    // String shapes for generated loads.
    localparam int SHAPE_FEW      = 0;
    localparam int SHAPE_WIDE     = 1;
    localparam int SHAPE_PERIODIC = 2;
    localparam int SHAPE_FLAT     = 3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    in_t  item = '0;
    logic busy;
    logic done;
    out_t result;

    suffix_array_lcp_kasai_core dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always #6 clk = ~clk;

    // Predicted state of the core.
    logic [SYM_IN_W-1:0] text_sym [0:DEPTH-1];
    int                  text_sa  [0:DEPTH-1];
    int                  rank_of  [0:DEPTH-1];
    int                  lcp_tab  [0:DEPTH-1];
    int                  text_len = 0;
    logic [CNT_W-1:0]    distinct_now = '0;

    out_t lcp_reads_due [$];
    in_t  pending_words [$];
    int   pending_gaps [$];
    int   idle_left = 0;
    int   errors = 0;
    int   words_queued = 0;
    bit   burst = 1'b0;

    // Stimulus-side copies used to build strings and sorted suffix arrays.
    logic [SYM_IN_W-1:0] gen_sym [0:DEPTH-1];
    int                  gen_sa  [0:DEPTH-1];
    int                  order   [0:DEPTH-1];
    int                  gen_prefix = 0;

    // Applies one accepted word to the predicted state; a final load reruns Kasai's walk.
    task automatic kasai_update(input in_t w);
        int n;
        int h;
        int u;
        int rk;
        int v;
        longint full_count;
        longint sum;
        out_t r;
        if (w.cmd == CMD_LOAD)
        begin
            text_sym[w.index] = w.symbol;
            text_sa[w.index] = int'(w.suffix_pos);
            if (w.last)
            begin
                n = int'(w.index) + 1;
                text_len = n;
                h = 0;
                for (u = 0; u < n; u++)
                begin
                    rank_of[u] = n - 1;
                    lcp_tab[u] = 0;
                end
                // Entries past the length are skipped; duplicates keep the later rank.
                for (u = 0; u < n; u++)
                begin
                    if (text_sa[u] < n)
                        rank_of[text_sa[u]] = u;
                end
                for (u = 0; u < n; u++)
                begin
                    rk = rank_of[u];
                    if (rk + 1 >= n)
                    begin
                        h = 0;
                    end
                    else
                    begin
                        v = text_sa[rk + 1];
                        while (u + h < n && v + h < n && text_sym[u + h] == text_sym[v + h])
                            h++;
                        lcp_tab[rk] = (h > int'(LCP_MAX)) ? int'(LCP_MAX) : h;
                        if (h > 0)
                            h--;
                    end
                end
                full_count = longint'(n) * longint'(n + 1) / 2;
                sum = 0;
                for (u = 0; u + 1 < n; u++)
                    sum += lcp_tab[u];
                if (sum >= full_count)
                    distinct_now = '0;
                else if (full_count - sum > COUNT_TOP)
                    distinct_now = CNT_W'(COUNT_TOP);
                else
                    distinct_now = CNT_W'(full_count - sum);
            end
        end
        else
        begin
            if (int'(w.index) + 1 < text_len)
            begin
                r.lcp_value = LCP_W'(lcp_tab[w.index]);
                r.out_of_range = 1'b0;
            end
            else
            begin
                r.lcp_value = '0;
                r.out_of_range = 1'b1;
            end
            r.distinct_count = distinct_now;
            lcp_reads_due.push_back(r);
        end
    endtask

    // Queues one word with a random idle gap ahead of it; unused read fields get noise.
    task automatic queue_word(input logic op, input int idx, input int sym, input int spos,
                              input logic fin);
        in_t w;
        int gap;
        int roll;
        w.cmd = op;
        w.index = IDX_W'(idx);
        if (op == CMD_READ)
        begin
            w.symbol = SYM_IN_W'($urandom);
            w.suffix_pos = IDX_W'($urandom);
            w.last = 1'($urandom);
        end
        else
        begin
            w.symbol = SYM_IN_W'(sym);
            w.suffix_pos = IDX_W'(spos);
            w.last = fin;
        end
        roll = $urandom_range(0, 99);
        if (burst || roll < 50)
            gap = 0;
        else if (roll < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 40);
        pending_words.push_back(w);
        pending_gaps.push_back(gap);
        words_queued++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        logic [63:0] junk;
        in_t nxt;
        junk = {$urandom, $urandom};
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
            idle_left = 0;
        end
        else
        begin
            if (start && !busy)
                kasai_update(item);
            if (start && busy)
            begin
                // The word is still waiting to be taken; hold it.
            end
            else if (idle_left > 0)
            begin
                idle_left--;
                start <= 1'b0;
                item <= junk[$bits(in_t)-1:0];
            end
            else if (pending_words.size() == 0)
            begin
                start <= 1'b0;
                item <= junk[$bits(in_t)-1:0];
            end
            else if (pending_gaps[0] > 0)
            begin
                idle_left = pending_gaps[0] - 1;
                pending_gaps[0] = 0;
                start <= 1'b0;
                item <= junk[$bits(in_t)-1:0];
            end
            else
            begin
                nxt = pending_words.pop_front();
                void'(pending_gaps.pop_front());
                item <= nxt;
                start <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check
        out_t want;
        if (rst_n && done)
        begin
            if (lcp_reads_due.size() == 0)
            begin
                $error("result word with no read waiting for it");
                errors++;
            end
            else
            begin
                want = lcp_reads_due.pop_front();
                if (result.lcp_value !== want.lcp_value)
                begin
                    $error("lcp_value expected %0d actual %0d", want.lcp_value,
                           result.lcp_value);
                    errors++;
                end
                if (result.distinct_count !== want.distinct_count)
                begin
                    $error("distinct_count expected %0d actual %0d", want.distinct_count,
                           result.distinct_count);
                    errors++;
                end
                if (result.out_of_range !== want.out_of_range)
                begin
                    $error("out_of_range expected %0d actual %0d", want.out_of_range,
                           result.out_of_range);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int seq;
        int big_at;
        int mid_at;
        int n;
        int i;
        int j;
        int k;
        int t;
        int key;
        int shape;
        int base;
        int span;
        int period;
        int mode;
        int reads;
        int strays;
        int idx;
        bit less;
        bit moving;
        logic [SYM_IN_W-1:0] motif [0:3];

        // Directed part. Nothing loaded yet, so every read is out of range.
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        queue_word(CMD_READ, DEPTH - 1, 0, 0, 1'b0);
        // One-symbol string: no LCP entry at all, count of one.
        queue_word(CMD_LOAD, 0, 16'hFFFF, 0, 1'b1);
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        // Two equal symbols, then reads on both sides of the end.
        queue_word(CMD_LOAD, 0, 0, 1, 1'b0);
        queue_word(CMD_LOAD, 1, 0, 0, 1'b1);
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        queue_word(CMD_READ, 1, 0, 0, 1'b0);
        queue_word(CMD_READ, DEPTH - 1, 0, 0, 1'b0);
        // A load after the run must leave the table and the count alone.
        queue_word(CMD_LOAD, 0, 7, 0, 1'b0);
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        // Every suffix entry past the length: no ranks, the walk stores nothing.
        queue_word(CMD_LOAD, 0, 16'hFFFF, DEPTH - 1, 1'b0);
        queue_word(CMD_LOAD, 1, 0, DEPTH - 1, 1'b0);
        queue_word(CMD_LOAD, 2, 16'hFFFF, DEPTH - 1, 1'b1);
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        queue_word(CMD_READ, 1, 0, 0, 1'b0);
        queue_word(CMD_READ, 2, 0, 0, 1'b0);
        // Duplicate suffix entries leave a position unranked.
        queue_word(CMD_LOAD, 0, 5, 2, 1'b0);
        queue_word(CMD_LOAD, 1, 5, 2, 1'b0);
        queue_word(CMD_LOAD, 2, 5, 0, 1'b1);
        queue_word(CMD_READ, 0, 0, 0, 1'b0);
        queue_word(CMD_READ, 1, 0, 0, 1'b0);
        gen_prefix = 3;

        // Random part: mostly whole strings with sorted suffix arrays, some broken.
        seq = 0;
        big_at = $urandom_range(5, 40);
        mid_at = $urandom_range(5, 40);
        while (words_queued < 2000)
        begin
            seq++;
            burst = ($urandom_range(0, 3) == 0);
            if (seq == big_at || seq == mid_at || $urandom_range(0, 9) != 0)
            begin
                if (seq == big_at)
                begin
                    n = DEPTH;
                    shape = SHAPE_FLAT;
                end
                else if (seq == mid_at)
                begin
                    n = $urandom_range(200, 400);
                    shape = SHAPE_WIDE;
                end
                else
                begin
                    k = $urandom_range(0, 19);
                    n = (k == 0) ? 1 : (k < 4) ? $urandom_range(25, 64) : $urandom_range(2, 24);
                    shape = $urandom_range(SHAPE_FEW, SHAPE_FLAT);
                end
                base = $urandom_range(0, 65535);
                span = $urandom_range(2, 4);
                period = $urandom_range(1, 4);
                for (i = 0; i < 4; i++)
                    motif[i] = SYM_IN_W'(base + $urandom_range(0, 1));
                for (i = 0; i < n; i++)
                begin
                    case (shape)
                        SHAPE_FEW:      gen_sym[i] = SYM_IN_W'(base + $urandom_range(0, span - 1));
                        SHAPE_WIDE:     gen_sym[i] = SYM_IN_W'($urandom_range(0, 65535));
                        SHAPE_PERIODIC: gen_sym[i] = motif[i % period];
                        default:        gen_sym[i] = SYM_IN_W'(base);
                    endcase
                end

                // Insertion sort of the suffixes; starting from reversed order keeps
                // flat strings cheap to sort.
                for (i = 0; i < n; i++)
                    gen_sa[i] = n - 1 - i;
                for (i = 1; i < n; i++)
                begin
                    key = gen_sa[i];
                    j = i - 1;
                    moving = 1'b1;
                    while (j >= 0 && moving)
                    begin
                        k = 0;
                        while (key + k < n && gen_sa[j] + k < n &&
                               gen_sym[key + k] == gen_sym[gen_sa[j] + k])
                            k++;
                        if (key + k == n)
                            less = 1'b1;
                        else if (gen_sa[j] + k == n)
                            less = 1'b0;
                        else
                            less = gen_sym[key + k] < gen_sym[gen_sa[j] + k];
                        if (less)
                        begin
                            gen_sa[j + 1] = gen_sa[j];
                            j--;
                        end
                        else
                        begin
                            moving = 1'b0;
                        end
                    end
                    gen_sa[j + 1] = key;
                end

                // Now and then spoil the suffix array.
                mode = $urandom_range(0, 19);
                if (mode == 0)
                begin
                    for (i = n - 1; i > 0; i--)
                    begin
                        j = $urandom_range(0, i);
                        t = gen_sa[i];
                        gen_sa[i] = gen_sa[j];
                        gen_sa[j] = t;
                    end
                end
                else if (mode == 1)
                begin
                    for (i = 0; i < n; i++)
                        gen_sa[i] = $urandom_range(0, DEPTH - 1);
                end
                else if (mode == 2)
                begin
                    gen_sa[$urandom_range(0, n - 1)] = gen_sa[$urandom_range(0, n - 1)];
                end

                // Loads in random order with the final one last.
                for (i = 0; i < n - 1; i++)
                    order[i] = i;
                for (i = n - 2; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    t = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                for (i = 0; i < n - 1; i++)
                begin
                    queue_word(CMD_LOAD, order[i], gen_sym[order[i]], gen_sa[order[i]], 1'b0);
                    if ($urandom_range(0, 19) == 0)
                        queue_word(CMD_READ, $urandom_range(0, DEPTH - 1), 0, 0, 1'b0);
                end
                queue_word(CMD_LOAD, n - 1, gen_sym[n - 1], gen_sa[n - 1], 1'b1);
                if (n > gen_prefix)
                    gen_prefix = n;
            end
            else
            begin
                // Rerun over stale stores: a final load inside the written prefix.
                n = $urandom_range(0, (gen_prefix - 1 < 80) ? gen_prefix - 1 : 80) + 1;
                queue_word(CMD_LOAD, n - 1, $urandom_range(0, 65535),
                           $urandom_range(0, DEPTH - 1), 1'b1);
            end

            reads = $urandom_range(2, 10);
            for (i = 0; i < reads; i++)
            begin
                if ($urandom_range(0, 9) < 7)
                    idx = $urandom_range(0, (n < DEPTH) ? n : DEPTH - 1);
                else
                    idx = $urandom_range(0, DEPTH - 1);
                queue_word(CMD_READ, idx, 0, 0, 1'b0);
            end
            if ($urandom_range(0, 4) == 0)
            begin
                strays = $urandom_range(1, 3);
                for (i = 0; i < strays; i++)
                    queue_word(CMD_LOAD, $urandom_range(0, DEPTH - 1), $urandom_range(0, 65535),
                               $urandom_range(0, DEPTH - 1), 1'b0);
                queue_word(CMD_READ, $urandom_range(0, (n < DEPTH) ? n : DEPTH - 1), 0, 0, 1'b0);
                queue_word(CMD_READ, $urandom_range(0, DEPTH - 1), 0, 0, 1'b0);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge so that every driver update has settled.
        @(negedge clk);
        while (pending_words.size() != 0 || start || busy || lcp_reads_due.size() != 0)
            @(negedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[filelist.f]
hdl/salcp_pkg.sv
hdl/salcp_ctrl.sv
hdl/salcp_dp.sv
hdl/suffix_array_lcp_kasai_core.sv
hdl/salcp_checker.sv
bench/tb.sv
